### design/mbwd_pkg.sv
// Shared types and constants for the microsecond busy-wait delay engine.
package mbwd_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned CHUNK_W    = 20;
    localparam int unsigned SCALE_SH   = 30;
    localparam int unsigned DIVIDEND_W = CHUNK_W + SCALE_SH;
    localparam int unsigned DIV_STEPS  = DIVIDEND_W;
    localparam int unsigned CNT_W      = $clog2(DIV_STEPS + 1);
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [DATA_W-1:0] CHUNK_US = 32'd1000000;
    localparam logic [DATA_W-1:0] DIVISOR_RESET = 32'd1;

    localparam logic [CFG_IDX_W-1:0] REG_TICK_DIVISOR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTER_24BIT = 1'd1;

    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ARMED = 2'd1,
        PH_COUNT = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_EMIT = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic              req_type;
        logic [DATA_W-1:0] delay_us;
        logic [DATA_W-1:0] counter_sample;
    } mbwd_in_t;

    typedef struct packed {
        logic              delay_done;
        logic              busy_res;
        logic [DATA_W-1:0] ticks_left;
    } mbwd_out_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic load_out;
    } mbwd_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } mbwd_status_t;

endpackage

### design/mbwd_ctrl.sv
// Sequencing state machine: takes a transaction, runs the divider, emits the result.
module mbwd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  mbwd_pkg::mbwd_status_t status,
    output mbwd_pkg::mbwd_cmd_t    cmd
);

    mbwd_pkg::ctrl_state_t state_reg;
    mbwd_pkg::ctrl_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbwd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mbwd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.need_div ? mbwd_pkg::ST_DIV : mbwd_pkg::ST_EMIT;
                end
            end
            mbwd_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = mbwd_pkg::ST_EMIT;
                end
            end
            mbwd_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = mbwd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mbwd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            mbwd_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            mbwd_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            mbwd_pkg::ST_EMIT:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // A new result may replace one that is being taken in the same cycle.
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### design/mbwd_dpath.sv
// Delay state, configuration registers, bit-serial chunk divider and result register.
module mbwd_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mbwd_pkg::mbwd_in_t                  in_data,
    output mbwd_pkg::mbwd_out_t                 out_data,
    input  logic                                cfg_we,
    input  logic [mbwd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mbwd_pkg::DATA_W-1:0]         cfg_data,
    input  mbwd_pkg::mbwd_cmd_t                 cmd,
    output mbwd_pkg::mbwd_status_t              status
);

    logic [mbwd_pkg::DATA_W-1:0]     tick_divisor_reg;
    logic                            counter_24bit_reg;
    logic [mbwd_pkg::DATA_W-1:0]     remaining_reg;
    logic [mbwd_pkg::DATA_W-1:0]     remaining_next;
    logic [mbwd_pkg::DATA_W-1:0]     baseline_reg;
    logic [mbwd_pkg::DATA_W-1:0]     baseline_next;
    logic [mbwd_pkg::DATA_W-1:0]     pending_reg;
    logic [mbwd_pkg::DATA_W-1:0]     pending_next;
    mbwd_pkg::phase_t                phase_reg;
    mbwd_pkg::phase_t                phase_next;
    logic                            done_reg;
    logic                            done_next;

    logic [mbwd_pkg::DIVIDEND_W-1:0] dividend_reg;
    logic [mbwd_pkg::DATA_W-1:0]     divrem_reg;
    logic [mbwd_pkg::DATA_W-1:0]     quot_reg;
    logic [mbwd_pkg::CNT_W-1:0]      count_reg;

    mbwd_pkg::mbwd_out_t             out_reg;

    logic [mbwd_pkg::DATA_W-1:0]     delta_raw;
    logic [mbwd_pkg::DATA_W-1:0]     delta;
    logic                            chunk_over;
    logic [mbwd_pkg::DATA_W-1:0]     chunk_src;
    logic [mbwd_pkg::CHUNK_W-1:0]    chunk_us;
    logic                            load_div;
    logic [mbwd_pkg::DATA_W:0]       trial;
    logic                            q_bit;
    logic [mbwd_pkg::DATA_W-1:0]     quot_step;
    logic                            div_last;

    assign delta_raw  = in_data.counter_sample - baseline_reg;
    assign delta      = counter_24bit_reg ? {8'd0, delta_raw[23:0]} : delta_raw;
    assign chunk_over = remaining_reg <= delta;

    // The next chunk comes from the new request on a start, else from what is pending.
    assign chunk_src = (in_data.req_type == mbwd_pkg::REQ_START) ? in_data.delay_us
                                                                : pending_reg;
    assign chunk_us  = (chunk_src > mbwd_pkg::CHUNK_US) ? mbwd_pkg::CHUNK_US[mbwd_pkg::CHUNK_W-1:0]
                                                        : chunk_src[mbwd_pkg::CHUNK_W-1:0];

    always_comb
    begin
        remaining_next = remaining_reg;
        baseline_next  = baseline_reg;
        pending_next   = pending_reg;
        phase_next     = phase_reg;
        done_next      = 1'b0;
        load_div       = 1'b0;
        if (in_data.req_type == mbwd_pkg::REQ_START)
        begin
            if (in_data.delay_us == '0)
            begin
                remaining_next = '0;
                pending_next   = '0;
                phase_next     = mbwd_pkg::PH_IDLE;
                done_next      = 1'b1;
            end
            else
            begin
                load_div = 1'b1;
            end
        end
        else
        begin
            case (phase_reg)
                mbwd_pkg::PH_ARMED:
                begin
                    baseline_next = in_data.counter_sample;
                    phase_next    = mbwd_pkg::PH_COUNT;
                end
                mbwd_pkg::PH_COUNT:
                begin
                    if (chunk_over)
                    begin
                        if (pending_reg == '0)
                        begin
                            remaining_next = '0;
                            phase_next     = mbwd_pkg::PH_IDLE;
                            done_next      = 1'b1;
                        end
                        else
                        begin
                            load_div = 1'b1;
                        end
                    end
                    else
                    begin
                        remaining_next = remaining_reg - delta;
                        baseline_next  = in_data.counter_sample;
                    end
                end
                default:
                begin
                    phase_next     = mbwd_pkg::PH_IDLE;
                    remaining_next = '0;
                end
            endcase
        end
        if (load_div)
        begin
            pending_next = chunk_src - {12'd0, chunk_us};
            phase_next   = mbwd_pkg::PH_ARMED;
        end
    end

    // Restoring division, one quotient bit per cycle; upper quotient bits fall off the top.
    assign trial     = {divrem_reg, dividend_reg[mbwd_pkg::DIVIDEND_W-1]};
    assign q_bit     = trial >= {1'b0, tick_divisor_reg};
    assign quot_step = {quot_reg[mbwd_pkg::DATA_W-2:0], q_bit};
    assign div_last  = count_reg == mbwd_pkg::CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_divisor_reg  <= mbwd_pkg::DIVISOR_RESET;
            counter_24bit_reg <= 1'b0;
            remaining_reg     <= '0;
            baseline_reg      <= '0;
            pending_reg       <= '0;
            phase_reg         <= mbwd_pkg::PH_IDLE;
            done_reg          <= 1'b0;
            count_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mbwd_pkg::REG_TICK_DIVISOR:  tick_divisor_reg  <= cfg_data;
                    mbwd_pkg::REG_COUNTER_24BIT: counter_24bit_reg <= cfg_data[0];
                    default:                     tick_divisor_reg  <= tick_divisor_reg;
                endcase
            end
            if (cmd.accept)
            begin
                remaining_reg <= remaining_next;
                baseline_reg  <= baseline_next;
                pending_reg   <= pending_next;
                phase_reg     <= phase_next;
                done_reg      <= done_next;
                if (load_div)
                begin
                    count_reg <= mbwd_pkg::CNT_W'(mbwd_pkg::DIV_STEPS);
                end
            end
            else if (cmd.div_step)
            begin
                count_reg <= count_reg - mbwd_pkg::CNT_W'(1);
                if (div_last)
                begin
                    remaining_reg <= quot_step;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && load_div)
        begin
            dividend_reg <= {chunk_us, {mbwd_pkg::SCALE_SH{1'b0}}};
            divrem_reg   <= '0;
            quot_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            dividend_reg <= {dividend_reg[mbwd_pkg::DIVIDEND_W-2:0], 1'b0};
            divrem_reg   <= q_bit ? 32'(trial - {1'b0, tick_divisor_reg}) : trial[31:0];
            quot_reg     <= quot_step;
        end
        if (cmd.load_out)
        begin
            out_reg.delay_done <= done_reg;
            out_reg.busy_res   <= (phase_reg == mbwd_pkg::PH_ARMED)
                                  || (phase_reg == mbwd_pkg::PH_COUNT);
            out_reg.ticks_left <= (phase_reg == mbwd_pkg::PH_IDLE) ? '0 : remaining_reg;
        end
    end

    assign status.need_div = load_div;
    assign status.div_last = div_last;
    assign out_data        = out_reg;

endmodule

### design/microsecond_busy_wait_delay.sv
// Top level of the microsecond busy-wait delay engine.
// Each input transaction yields exactly one result transaction. A nonzero start, or a
// counter sample that closes a chunk while more microseconds are pending, loads a new
// chunk of at most one million microseconds whose tick count (chunk_us << 30) /
// tick_divisor is produced by a bit-serial restoring divider, one quotient bit per
// cycle (take, 50 divider steps, result load); any other is a take and a result load.
// A new transaction is taken while the previous result waits in the output register.
// The user must write configuration only when idle; the block does not enforce it.
module microsecond_busy_wait_delay (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  mbwd_pkg::mbwd_in_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output mbwd_pkg::mbwd_out_t              out_data,
    input  logic                             cfg_we,
    input  logic [mbwd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mbwd_pkg::DATA_W-1:0]      cfg_data
);

    mbwd_pkg::mbwd_cmd_t    cmd;
    mbwd_pkg::mbwd_status_t status;

    mbwd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mbwd_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the microsecond busy-wait delay engine.
module tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_PRINTED = 40;
    localparam logic [mbwd_pkg::DATA_W-1:0] DIV_10MHZ = 32'd107374182;
    localparam logic [mbwd_pkg::DATA_W-1:0] DIV_1GHZ = 32'd1073741;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    mbwd_pkg::mbwd_in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    mbwd_pkg::mbwd_out_t out_data;
    logic cfg_we = 1'b0;
    logic [mbwd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mbwd_pkg::DATA_W-1:0] cfg_data = '0;

    // Predicted state of the delay engine and its registers.
    logic [mbwd_pkg::DATA_W-1:0] tick_div = mbwd_pkg::DIVISOR_RESET;
    logic narrow_counter = 1'b0;
    logic [mbwd_pkg::DATA_W-1:0] ticks_remaining = '0;
    logic [mbwd_pkg::DATA_W-1:0] chunk_base = '0;
    logic [mbwd_pkg::DATA_W-1:0] us_pending = '0;
    mbwd_pkg::phase_t delay_phase = mbwd_pkg::PH_IDLE;
    mbwd_pkg::mbwd_out_t expected_results[$];

    // Emulated free-running counter that feeds the sample transactions.
    logic [mbwd_pkg::DATA_W-1:0] free_counter = '0;

    int gap_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int items_sent = 0;
    int items_effective = 0;
    int results_seen = 0;
    int delays_done = 0;
    int chunks_loaded = 0;

    microsecond_busy_wait_delay DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when a test asks for one.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic report_mismatch(input string what,
                                   input logic [mbwd_pkg::DATA_W-1:0] got,
                                   input logic [mbwd_pkg::DATA_W-1:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch at cycle %0d: %s got %h expected %h",
                     cycle_count, what, got, want);
    endtask

    always @(posedge clk)
    begin : check_results
        mbwd_pkg::mbwd_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                report_mismatch("result transaction with nothing pending",
                                out_data.ticks_left, '0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data.delay_done !== want.delay_done)
                    report_mismatch("delay_done", {31'd0, out_data.delay_done},
                                    {31'd0, want.delay_done});
                if (out_data.busy_res !== want.busy_res)
                    report_mismatch("busy_res", {31'd0, out_data.busy_res},
                                    {31'd0, want.busy_res});
                if (out_data.ticks_left !== want.ticks_left)
                    report_mismatch("ticks_left", out_data.ticks_left, want.ticks_left);
            end
        end
    end

    // Takes the next chunk of at most one million microseconds off the pending time.
    function automatic void load_next_chunk();
        logic [mbwd_pkg::DATA_W-1:0] us;
        logic [63:0] scaled;
        us = (us_pending > mbwd_pkg::CHUNK_US) ? mbwd_pkg::CHUNK_US : us_pending;
        us_pending -= us;
        scaled = {32'd0, us} << mbwd_pkg::SCALE_SH;
        ticks_remaining = (tick_div == '0) ? '1
                                           : mbwd_pkg::DATA_W'(scaled / {32'd0, tick_div});
        delay_phase = mbwd_pkg::PH_ARMED;
        chunks_loaded++;
    endfunction

    function automatic mbwd_pkg::mbwd_out_t apply_transaction(input mbwd_pkg::mbwd_in_t item);
        mbwd_pkg::mbwd_out_t res;
        logic [mbwd_pkg::DATA_W-1:0] delta;
        res.delay_done = 1'b0;
        if (item.req_type == mbwd_pkg::REQ_START)
        begin
            if (item.delay_us == '0)
            begin
                ticks_remaining = '0;
                us_pending = '0;
                delay_phase = mbwd_pkg::PH_IDLE;
                res.delay_done = 1'b1;
            end
            else
            begin
                us_pending = item.delay_us;
                load_next_chunk();
            end
        end
        else if (delay_phase == mbwd_pkg::PH_ARMED)
        begin
            chunk_base = item.counter_sample;
            delay_phase = mbwd_pkg::PH_COUNT;
        end
        else if (delay_phase == mbwd_pkg::PH_COUNT)
        begin
            delta = item.counter_sample - chunk_base;
            if (narrow_counter)
                delta[31:24] = '0;
            if (ticks_remaining <= delta)
            begin
                if (us_pending == '0)
                begin
                    ticks_remaining = '0;
                    delay_phase = mbwd_pkg::PH_IDLE;
                    res.delay_done = 1'b1;
                end
                else
                begin
                    load_next_chunk();
                end
            end
            else
            begin
                ticks_remaining -= delta;
                chunk_base = item.counter_sample;
            end
        end
        else
        begin
            delay_phase = mbwd_pkg::PH_IDLE;
            ticks_remaining = '0;
        end
        res.busy_res = (delay_phase != mbwd_pkg::PH_IDLE);
        res.ticks_left = (delay_phase == mbwd_pkg::PH_IDLE) ? '0 : ticks_remaining;
        if (res.delay_done)
            delays_done++;
        return res;
    endfunction

    task automatic send_item(input mbwd_pkg::mbwd_in_t item);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // A sample while idle is only ignored by the block.
        if (!(item.req_type == mbwd_pkg::REQ_SAMPLE && delay_phase == mbwd_pkg::PH_IDLE))
            items_effective++;
        items_sent++;
        expected_results.push_back(apply_transaction(item));
    endtask

    task automatic send_start(input logic [mbwd_pkg::DATA_W-1:0] us);
        mbwd_pkg::mbwd_in_t item;
        item.req_type = mbwd_pkg::REQ_START;
        item.delay_us = us;
        item.counter_sample = $urandom();
        send_item(item);
    endtask

    task automatic send_sample(input logic [mbwd_pkg::DATA_W-1:0] value);
        mbwd_pkg::mbwd_in_t item;
        item.req_type = mbwd_pkg::REQ_SAMPLE;
        item.delay_us = $urandom();
        item.counter_sample = value;
        send_item(item);
    endtask

    task automatic write_reg(input logic [mbwd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mbwd_pkg::DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == mbwd_pkg::REG_TICK_DIVISOR)
            tick_div = value;
        else if (idx == mbwd_pkg::REG_COUNTER_24BIT)
            narrow_counter = value[0];
    endtask

    // Registers change only once every result is out and the block is quiet.
    task automatic reconfigure(input logic [mbwd_pkg::DATA_W-1:0] divisor, input logic narrow);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(mbwd_pkg::REG_TICK_DIVISOR, divisor);
        write_reg(mbwd_pkg::REG_COUNTER_24BIT, {31'd0, narrow});
    endtask

    // Counter advance chosen so that chunks end exactly, early, late or after many samples.
    function automatic logic [mbwd_pkg::DATA_W-1:0] pick_step();
        logic [mbwd_pkg::DATA_W-1:0] span;
        logic [mbwd_pkg::DATA_W-1:0] aim;
        span = narrow_counter ? 32'h00FF_FFFF : 32'hFFFF_FFFF;
        aim = (ticks_remaining > span) ? span : ticks_remaining;
        case ($urandom_range(0, 9))
            0, 1, 2: pick_step = aim;
            3, 4:    pick_step = aim >> 1;
            5:       pick_step = $urandom_range(0, 15);
            6:       pick_step = $urandom();
            default: pick_step = (aim > span - 32'd4096) ? span : aim + $urandom_range(0, 4095);
        endcase
    endfunction

    task automatic run_delay(input logic [mbwd_pkg::DATA_W-1:0] us, input int max_samples);
        int n;
        send_start(us);
        n = 0;
        while (delay_phase != mbwd_pkg::PH_IDLE && n < max_samples)
        begin
            free_counter += pick_step();
            send_sample(free_counter);
            n++;
        end
    endtask

    task automatic test_idle_and_zero_delay();
        send_sample(32'hFFFF_FFFF);
        send_start('0);
        send_start(32'd1);
        send_sample('0);
        send_sample(32'h3FFF_FFFF);
        send_sample(32'h4000_0000);
        // The counter wraps between baseline and the closing sample.
        send_start(32'd1);
        send_sample(32'hC000_0000);
        send_sample('0);
    endtask

    task automatic test_saturation_and_zero_ticks();
        reconfigure('0, 1'b0);
        send_start(32'hFFFF_FFFF);
        send_sample('0);
        send_sample(32'hFFFF_FFFF);
        send_start(32'd2);
        send_start('0);
        reconfigure(32'hFFFF_FFFF, 1'b0);
        send_start(32'd1);
        send_sample(32'd5);
        send_sample(32'd5);
    endtask

    task automatic test_counter_24bit();
        reconfigure(DIV_10MHZ, 1'b1);
        send_start(mbwd_pkg::CHUNK_US);
        send_sample(32'h00FF_FFF0);
        send_sample(32'h0100_0010);
        send_sample(32'hFF00_0000);
    endtask

    task automatic test_multi_chunk();
        reconfigure(DIV_1GHZ, 1'b0);
        run_delay(32'd2000001, 60);
    endtask

    task automatic test_random_traffic(input int n_items, input int gap, input int stall,
                                       input logic [mbwd_pkg::DATA_W-1:0] divisor,
                                       input logic narrow);
        int stop_at;
        mbwd_pkg::mbwd_in_t noise;
        reconfigure(divisor, narrow);
        gap_pct = gap;
        stall_pct = stall;
        stop_at = items_effective + n_items;
        while (items_effective < stop_at)
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    noise.req_type = 1'($urandom_range(0, 1));
                    noise.delay_us = $urandom();
                    noise.counter_sample = $urandom();
                    send_item(noise);
                end
                1: send_start('0);
                2:
                begin
                    free_counter += $urandom();
                    send_sample(free_counter);
                end
                3:       run_delay($urandom(), $urandom_range(2, 12));
                4, 5:    run_delay($urandom_range(1, 50), 60);
                6, 7, 8: run_delay($urandom_range(1000001, 3500000), 60);
                default: run_delay($urandom_range(1, 1000000), 60);
            endcase
        end
    endtask

    // The receiver holds off while starts and samples keep coming, so the input backs up.
    task automatic test_backpressure();
        reconfigure(DIV_10MHZ, 1'b0);
        gap_pct = 0;
        stall_pct = 0;
        hold_request = 400;
        run_delay(32'd2500000, 60);
        repeat (6) run_delay($urandom_range(1, 1000000), 30);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_and_zero_delay();
        test_saturation_and_zero_ticks();
        test_counter_24bit();
        test_multi_chunk();
        test_random_traffic(450, 0, 0, DIV_10MHZ, 1'b0);
        test_random_traffic(360, 47, 0, DIV_1GHZ, 1'b0);
        test_random_traffic(360, 0, 47, $urandom_range(32'd64000000, 32'hFFFF_FFFF), 1'b1);
        test_random_traffic(280, 38, 38, 32'hFFFF_FFFF, 1'b0);
        test_random_traffic(280, 38, 38, mbwd_pkg::DIVISOR_RESET, 1'b0);
        test_backpressure();

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d transactions and checked %0d results; %0d chunks loaded, %0d %s",
                 items_sent, results_seen, chunks_loaded, delays_done, "delays done.");
        $display("Divisors zero, one, maximum and two timer rates; 24-bit and 32-bit counters.");
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
